### design/i2cm_pkg.sv
// i2cm_pkg: shared types and constants of the I2C master sequencer.
// Standalone; imported by the core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6
  } op_t;

  localparam logic [7:0] SLOT_TICKS_RESET = 8'd7;

  localparam logic [4:0] LAST_SLOT_START = 5'd3;
  localparam logic [4:0] LAST_SLOT_WRITE = 5'd26;
  localparam logic [4:0] LAST_SLOT_READ  = 5'd16;
  localparam logic [4:0] LAST_SLOT_SHORT = 5'd2;
  localparam logic [4:0] WRITE_REL_SLOT  = 5'd24;
  localparam logic [4:0] WRITE_ACK_SLOT  = 5'd25;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
    logic       dropped;
  } res_t;

endpackage

`default_nettype wire

### design/i2cm_if.sv
// i2cm_if: valid/ready channel interfaces for tick input, result output and
// configuration writes. Depends on nothing beyond the language.
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       sda_level;

  modport source (output valid, command, tx_byte, sda_level, input ready);
  modport sink (input valid, command, tx_byte, sda_level, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack_seen;
  logic       dropped;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  nack_seen, dropped, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                nack_seen, dropped, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### design/i2c_master_sequencer.sv
// i2c_master_sequencer: top level with tick input, result output and
// configuration channels. Depends on i2cm_pkg, i2cm_if and i2cm_core.
// Throughput: one tick per cycle while the skid register is empty. Results
// are registered in the output register, or in a skid register while the
// output stalls, so input ready stays high while one result is pending.
// Reset: SCL and SDA released high, sequencer idle, slot_ticks 7, no result
// pending; configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_sequencer (
  input logic        clk,
  input logic        rst,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);
  import i2cm_pkg::*;

  logic  in_xfer;
  in_t   in_item;
  res_t  res;
  res_t  out_res;
  res_t  skid_res;
  logic  out_valid;
  logic  skid_valid;

  assign in_ch.ready  = !skid_valid;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_item      = '{command:   in_ch.command,
                          tx_byte:   in_ch.tx_byte,
                          sda_level: in_ch.sda_level};

  i2cm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (in_xfer),
    .cfg_we   (cfg_ch.valid && cfg_ch.ready),
    .cfg_data (cfg_ch.data),
    .in_item  (in_item),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ch.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_valid) begin
      if (skid_valid) out_res <= skid_res;
      else if (in_xfer) out_res <= res;
    end else if (in_xfer) begin
      skid_res <= res;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.scl_out   = out_res.scl_out;
  assign out_ch.sda_out   = out_res.sda_out;
  assign out_ch.busy_res  = out_res.busy_res;
  assign out_ch.done_res  = out_res.done_res;
  assign out_ch.rx_byte   = out_res.rx_byte;
  assign out_ch.nack_seen = out_res.nack_seen;
  assign out_ch.dropped   = out_res.dropped;

endmodule

`default_nettype wire

### design/i2cm_core.sv
// i2cm_core: slot sequencer state and the single-pass next-state logic for
// one tick. Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_data,
  input  i2cm_pkg::in_t  in_item,
  output i2cm_pkg::res_t res
);
  import i2cm_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
  } lines_t;

  op_t        op;
  logic [4:0] slot_index;
  logic [1:0] phase;
  logic [7:0] tick_count;
  logic [7:0] shift_reg;
  logic [7:0] read_value;
  logic       ack_flag;
  logic       scl_level;
  logic       sda_drive;
  logic [7:0] slot_ticks;

  op_t        op_a;
  logic [4:0] slot_a;
  logic [1:0] phase_a;
  logic [7:0] tick_a;
  logic       start_cmd;
  logic       cmd_valid;
  logic       slot_end;
  logic       last;
  logic       drop;
  logic       done;

  op_t        op_next;
  logic [4:0] slot_index_next;
  logic [1:0] phase_next;
  logic [7:0] tick_count_next;
  logic [7:0] read_value_next;
  logic       ack_flag_next;
  lines_t     lines_a;
  lines_t     lines_b;
  lines_t     lines_next;

  function automatic logic [4:0] last_slot(op_t o);
    case (o)
      OP_START: return LAST_SLOT_START;
      OP_WRITE: return LAST_SLOT_WRITE;
      OP_READ:  return LAST_SLOT_READ;
      default:  return LAST_SLOT_SHORT;
    endcase
  endfunction

  function automatic lines_t apply_slot(op_t o, logic [4:0] i, logic [1:0] ph, lines_t cur);
    lines_t r;
    r = cur;
    case (o)
      OP_START: begin
        if (i == 5'd0) r.sda = 1'b1;
        else if (i == 5'd1) r.scl = 1'b1;
        else if (i == 5'd2) r.sda = 1'b0;
        else r.scl = 1'b0;
      end
      OP_STOP: begin
        if (i == 5'd0) r.sda = 1'b0;
        else if (i == 5'd1) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      OP_ACK, OP_NACK: begin
        if (i == 5'd0) r.sda = (o == OP_NACK);
        else if (i == 5'd1) r.scl = 1'b1;
        else r.scl = 1'b0;
      end
      OP_WRITE: begin
        if (i == WRITE_REL_SLOT) begin
          r.sda = 1'b1;
        end else if (ph == 2'd0) begin
          r.sda   = cur.shift[7];
          r.shift = {cur.shift[6:0], 1'b0};
        end else begin
          r.scl = (ph == 2'd1);
        end
      end
      OP_READ: begin
        if (i == 5'd0) r.sda = 1'b1;
        else r.scl = i[0];
      end
      default: ;
    endcase
    return r;
  endfunction

  assign cmd_valid = (in_item.command >= 3'd1) && (in_item.command <= 3'd6);

  always_comb begin
    op_a      = op;
    slot_a    = slot_index;
    phase_a   = phase;
    tick_a    = tick_count;
    start_cmd = 1'b0;
    drop      = 1'b0;
    if (op != OP_IDLE) begin
      drop   = cmd_valid;
      tick_a = tick_count + 8'd1;
    end else if (cmd_valid) begin
      op_a      = op_t'(in_item.command);
      slot_a    = 5'd0;
      phase_a   = 2'd0;
      tick_a    = 8'd1;
      start_cmd = 1'b1;
    end
    slot_end = (op_a != OP_IDLE) && (tick_a >= slot_ticks);
    last     = (slot_a == last_slot(op_a));

    op_next         = op_a;
    slot_index_next = slot_a;
    phase_next      = phase_a;
    tick_count_next = tick_a;
    done            = 1'b0;
    if (slot_end) begin
      tick_count_next = 8'd0;
      if (last) begin
        op_next         = OP_IDLE;
        slot_index_next = 5'd0;
        done            = 1'b1;
      end else begin
        slot_index_next = slot_a + 5'd1;
        phase_next      = (phase_a == 2'd2) ? 2'd0 : phase_a + 2'd1;
      end
    end
  end

  always_comb begin
    lines_a = '{scl: scl_level, sda: sda_drive, shift: shift_reg};
    if (start_cmd) begin
      lines_a.shift = (op_a == OP_WRITE) ? in_item.tx_byte : 8'd0;
      lines_a       = apply_slot(op_a, 5'd0, 2'd0, lines_a);
    end

    lines_b       = lines_a;
    ack_flag_next = ack_flag;
    if (slot_end) begin
      if (op_a == OP_WRITE && slot_a == WRITE_ACK_SLOT) begin
        ack_flag_next = in_item.sda_level;
      end else if (op_a == OP_READ && slot_a[0]) begin
        lines_b.shift = {lines_a.shift[6:0], in_item.sda_level};
      end
    end

    read_value_next = read_value;
    if (slot_end && last && op_a == OP_READ) read_value_next = lines_b.shift;

    if (slot_end && !last) lines_next = apply_slot(op_a, slot_index_next, phase_next, lines_b);
    else lines_next = lines_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= OP_IDLE;
      slot_index <= 5'd0;
      phase      <= 2'd0;
      tick_count <= 8'd0;
      shift_reg  <= 8'd0;
      read_value <= 8'd0;
      ack_flag   <= 1'b0;
      scl_level  <= 1'b1;
      sda_drive  <= 1'b1;
    end else if (step) begin
      op         <= op_next;
      slot_index <= slot_index_next;
      phase      <= phase_next;
      tick_count <= tick_count_next;
      shift_reg  <= lines_next.shift;
      read_value <= read_value_next;
      ack_flag   <= ack_flag_next;
      scl_level  <= lines_next.scl;
      sda_drive  <= lines_next.sda;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks <= SLOT_TICKS_RESET;
    end else if (cfg_we) begin
      slot_ticks <= cfg_data;
    end
  end

  assign res = '{scl_out:   lines_next.scl,
                 sda_out:   lines_next.sda,
                 busy_res:  (op_next != OP_IDLE),
                 done_res:  done,
                 rx_byte:   read_value_next,
                 nack_seen: ack_flag_next,
                 dropped:   drop};

endmodule

`default_nettype wire

### design/i2cm_checker.sv
// i2cm_checker: port-level assertions for i2c_master_sequencer and the bind
// that attaches them. Depends on i2cm_if and the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
  input logic        clk,
  input logic        rst,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);

  // hold a stalled result: valid, rx_byte, scl_out, sda_out and done_res
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.rx_byte)
      && $stable(out_ch.scl_out) && $stable(out_ch.sda_out)
      && $stable(out_ch.done_res))
    else $error("stalled result changed");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done with sequencer still busy");

  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.dropped |-> out_ch.busy_res || out_ch.done_res)
    else $error("command dropped while idle");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_ch.valid && in_ch.ready && cfg_ch.ready)
    else $error("result pending after reset");

endmodule

bind i2c_master_sequencer i2cm_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch),
  .cfg_ch (cfg_ch)
);

`default_nettype wire
